FILE: hdl/fgpd_pkg.sv
package fgpd_pkg;

   // Full scale of the quantized universe, 3.0 in Q.9.
   localparam logic [11:0] Q_FULL   = 12'd1536;
   // One membership unit, 1.0 in Q.9.
   localparam logic [9:0]  W_ONE    = 10'd512;
   // Largest rule sum magnitude, 6 * 2^18.
   localparam logic [20:0] S_MAX    = 21'd1572864;
   localparam logic [13:0] SIX      = 14'd6;

   localparam logic [13:0] ERR_LIMIT_RST = 14'd160;
   localparam logic [13:0] EC_LIMIT_RST  = 14'd10;
   localparam logic [14:0] OUT_LIMIT_RST = 15'd600;
   localparam logic [15:0] KP_BASE_RST   = 16'd1101;
   localparam logic [15:0] KD_BASE_RST   = 16'd38;
   localparam logic [15:0] KP_FUZZY_RST  = 16'd2048;
   localparam logic [15:0] KD_FUZZY_RST  = 16'd0;

   typedef enum logic [2:0] {
      CSR_ERR_LIMIT = 3'd0,
      CSR_EC_LIMIT  = 3'd1,
      CSR_OUT_LIMIT = 3'd2,
      CSR_KP_BASE   = 3'd3,
      CSR_KD_BASE   = 3'd4,
      CSR_KP_FUZZY  = 3'd5,
      CSR_KD_FUZZY  = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic signed [15:0] setpoint;
      logic signed [15:0] measured;
   } req_type;

   typedef struct packed {
      logic signed [15:0] drive;
      logic               saturated;
   } rsp_type;

   // Start request for the serial multiplier. The multiplier operand is
   // left-aligned and consumed MSB first for count steps.
   typedef struct packed {
      logic        start;
      logic [20:0] mcand;
      logic [16:0] mplier;
      logic [4:0]  count;
   } mul_req_type;

   // Start request for the serial divider. rem_init must be below divisor;
   // bits holds the remaining dividend bits, left-aligned, MSB first.
   typedef struct packed {
      logic        start;
      logic [13:0] divisor;
      logic [13:0] rem_init;
      logic [15:0] bits;
      logic [4:0]  count;
   } div_req_type;

   // Rule table shared by the proportional and derivative schedules.
   localparam logic signed [3:0] RULE_TABLE [0:6][0:6] = '{
      '{ 4'sd6,  4'sd6,  4'sd4,  4'sd6,  4'sd4,  4'sd0,  4'sd0 },
      '{ 4'sd6,  4'sd6,  4'sd4,  4'sd4,  4'sd2,  4'sd0, -4'sd2 },
      '{ 4'sd4,  4'sd4,  4'sd2,  4'sd2,  4'sd0, -4'sd2, -4'sd2 },
      '{ 4'sd4,  4'sd4,  4'sd2,  4'sd0, -4'sd2, -4'sd4, -4'sd4 },
      '{ 4'sd2,  4'sd2,  4'sd0, -4'sd2, -4'sd2, -4'sd4, -4'sd4 },
      '{ 4'sd2,  4'sd0, -4'sd2, -4'sd4, -4'sd4, -4'sd6, -4'sd6 },
      '{ 4'sd0,  4'sd0, -4'sd4, -4'sd6, -4'sd4, -4'sd6, -4'sd6 }
   };

endpackage

FILE: hdl/fgpd_mul.sv
module fgpd_mul
   import fgpd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  mul_req_type req,
   output logic        done,
   output logic [37:0] product
);

   logic [37:0] prod_ff, prod_in;
   logic [20:0] mcand_ff, mcand_in;
   logic [16:0] mplier_ff, mplier_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;

   // One multiplier bit per cycle: shift the partial product left and add.
   always_comb begin
      prod_in   = prod_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      cnt_in    = cnt_ff;
      busy_in   = busy_ff;
      done_in   = 1'b0;
      if (req.start) begin
         prod_in   = '0;
         mcand_in  = req.mcand;
         mplier_in = req.mplier;
         cnt_in    = req.count;
         busy_in   = 1'b1;
      end else if (busy_ff) begin
         prod_in   = {prod_ff[36:0], 1'b0}
                     + (mplier_ff[16] ? {17'd0, mcand_ff} : 38'd0);
         mplier_in = {mplier_ff[15:0], 1'b0};
         cnt_in    = cnt_ff - 5'd1;
         if (cnt_ff == 5'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      prod_ff   <= prod_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      cnt_ff    <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done    = done_ff;
   assign product = prod_ff;

endmodule

FILE: hdl/fgpd_div.sv
module fgpd_div
   import fgpd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output logic        done,
   output logic [15:0] quotient
);

   logic [13:0] div_ff, div_in;
   logic [13:0] rem_ff, rem_in;
   logic [15:0] bits_ff, bits_in;
   logic [15:0] quo_ff, quo_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [14:0] trial;
   logic [14:0] diff;
   logic        ge;

   // Restoring division, one quotient bit per cycle.
   assign trial = {rem_ff, bits_ff[15]};
   assign ge    = trial >= {1'b0, div_ff};
   assign diff  = trial - {1'b0, div_ff};

   always_comb begin
      div_in  = div_ff;
      rem_in  = rem_ff;
      bits_in = bits_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (req.start) begin
         div_in  = req.divisor;
         rem_in  = req.rem_init;
         bits_in = req.bits;
         quo_in  = '0;
         cnt_in  = req.count;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = ge ? diff[13:0] : trial[13:0];
         bits_in = {bits_ff[14:0], 1'b0};
         quo_in  = {quo_ff[14:0], ge};
         cnt_in  = cnt_ff - 5'd1;
         if (cnt_ff == 5'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      div_ff  <= div_in;
      rem_ff  <= rem_in;
      bits_ff <= bits_in;
      quo_ff  <= quo_in;
      cnt_ff  <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

FILE: hdl/fuzzy_gain_scheduled_pd_core.sv
// Fuzzy gain-scheduled PD controller. Each request word carries a setpoint and
// a measurement; the block answers with one response word holding the
// saturated drive and a flag telling whether it was clipped. The error and its
// change are clamped, quantized onto three levels either side of zero, fuzzified
// over a 7x7 rule table, and the resulting rule strength scales kp and kd
// before the PD sum is formed. All products and quotients run through one
// bit-serial multiplier and one bit-serial divider: a word passes through two
// quantizing divisions, four rule products, two gain products each followed
// by a division by six, and two drive products, with start and handoff states
// around them. One word is processed at a time, so a new word is accepted
// only once the previous one has finished; a finished response waits in its
// output register while the next request word is already accepted. The user
// must write configuration through the csr port only while the block is idle;
// the block itself does not enforce it. An unknown index is ignored.
module fuzzy_gain_scheduled_pd_core
   import fgpd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data
);

   typedef enum logic [16:0] {
      ST_IDLE      = 17'b00000000000000001,
      ST_ERR       = 17'b00000000000000010,
      ST_EC        = 17'b00000000000000100,
      ST_QE        = 17'b00000000000001000,
      ST_QC        = 17'b00000000000010000,
      ST_MEMB      = 17'b00000000000100000,
      ST_RULE_GO   = 17'b00000000001000000,
      ST_RULE_WAIT = 17'b00000000010000000,
      ST_ABS       = 17'b00000000100000000,
      ST_GMUL_GO   = 17'b00000001000000000,
      ST_GMUL_WAIT = 17'b00000010000000000,
      ST_GDIV_WAIT = 17'b00000100000000000,
      ST_DMUL_GO   = 17'b00001000000000000,
      ST_DMUL_WAIT = 17'b00010000000000000,
      ST_COMB      = 17'b00100000000000000,
      ST_MAG       = 17'b01000000000000000,
      ST_FIN       = 17'b10000000000000000
   } state_type;

   // Configuration registers.
   logic [13:0] err_limit_ff, ec_limit_ff;
   logic [14:0] out_limit_ff;
   logic [15:0] kp_base_ff, kd_base_ff, kp_fuzzy_ff, kd_fuzzy_ff;

   state_type state_ff, state_in;

   logic signed [16:0] diff_ff, diff_in;
   logic signed [14:0] e_ff, e_in;
   logic signed [14:0] ec_ff, ec_in;
   logic signed [15:0] last_error_ff, last_error_in;
   logic [10:0]        qe_mag_ff, qe_mag_in, qc_mag_ff, qc_mag_in;
   logic [2:0]         ie_ff, ie_in, ic_ff, ic_in;
   logic [9:0]         we0_ff, we0_in, we1_ff, we1_in;
   logic [9:0]         wc0_ff, wc0_in, wc1_ff, wc1_in;
   logic [1:0]         term_ff, term_in;
   logic               rneg_ff, rneg_in;
   logic signed [22:0] s_ff, s_in;
   logic [20:0]        abs_s_ff, abs_s_in;
   logic               gsel_ff, gsel_in;
   logic               dsel_ff, dsel_in;
   logic [16:0]        kp_ff, kp_in, kd_ff, kd_in;
   logic [31:0]        pe_ff, pe_in, pc_ff, pc_in;
   logic signed [33:0] acc_ff, acc_in;
   logic [24:0]        mag_ff, mag_in;
   logic               neg_ff, neg_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   mul_req_type mul_req;
   div_req_type div_req;
   logic        mul_done, div_done;
   logic [37:0] mul_prod;
   logic [15:0] div_quo;

   fgpd_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .req     (mul_req),
      .done    (mul_done),
      .product (mul_prod)
   );

   fgpd_div u_div (
      .clock    (clock),
      .reset    (reset),
      .req      (div_req),
      .done     (div_done),
      .quotient (div_quo)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Error and error-change clamping.
   logic signed [16:0] lim_e17, lim_c17, e_clamp, ec_raw, ec_clamp;
   assign lim_e17 = signed'({3'b000, err_limit_ff});
   assign lim_c17 = signed'({3'b000, ec_limit_ff});
   assign e_clamp = (diff_ff > lim_e17) ? lim_e17 :
                    (diff_ff < -lim_e17) ? -lim_e17 : diff_ff;
   assign ec_raw  = 17'(e_ff) - 17'(last_error_ff);
   assign ec_clamp = (ec_raw > lim_c17) ? lim_c17 :
                     (ec_raw < -lim_c17) ? -lim_c17 : ec_raw;

   // Magnitudes of the clamped error terms.
   logic [14:0] e_neg15, ec_neg15;
   logic [13:0] e_mag, ec_mag;
   logic [15:0] e_mag3, ec_mag3;
   assign e_neg15  = -e_ff;
   assign ec_neg15 = -ec_ff;
   assign e_mag    = e_ff[14] ? e_neg15[13:0] : e_ff[13:0];
   assign ec_mag   = ec_ff[14] ? ec_neg15[13:0] : ec_ff[13:0];
   assign e_mag3   = {1'b0, e_mag, 1'b0} + {2'b00, e_mag};
   assign ec_mag3  = {1'b0, ec_mag, 1'b0} + {2'b00, ec_mag};

   // Triangular membership: segment index and upper/lower weights.
   logic [11:0] off_e, off_c;
   assign off_e = e_ff[14] ? (Q_FULL - {1'b0, qe_mag_ff}) : (Q_FULL + {1'b0, qe_mag_ff});
   assign off_c = ec_ff[14] ? (Q_FULL - {1'b0, qc_mag_ff}) : (Q_FULL + {1'b0, qc_mag_ff});

   logic [2:0] seg_e, seg_c;
   logic [9:0] wup_e, wup_c;
   assign seg_e = (off_e[11:9] == 3'd6) ? 3'd5 : off_e[11:9];
   assign seg_c = (off_c[11:9] == 3'd6) ? 3'd5 : off_c[11:9];
   assign wup_e = (off_e[11:9] == 3'd6) ? W_ONE : {1'b0, off_e[8:0]};
   assign wup_c = (off_c[11:9] == 3'd6) ? W_ONE : {1'b0, off_c[8:0]};

   // Rule term selection for the current corner of the active cell.
   logic [2:0]        row, col;
   logic signed [3:0] rule_val;
   logic [3:0]        rule_neg;
   logic [3:0]        rule_abs;
   logic [9:0]        w_sel_e, w_sel_c;
   logic [12:0]       rule_mcand;
   assign row      = ie_ff + {2'b00, term_ff[1]};
   assign col      = ic_ff + {2'b00, term_ff[0]};
   assign rule_val = RULE_TABLE[row][col];
   assign rule_neg = -rule_val;
   assign rule_abs = rule_val[3] ? rule_neg : rule_val;
   assign w_sel_e  = term_ff[1] ? we1_ff : we0_ff;
   assign w_sel_c  = term_ff[0] ? wc1_ff : wc0_ff;
   assign rule_mcand = (rule_abs[2] ? {1'b0, w_sel_e, 2'b00} : 13'd0)
                       + (rule_abs[1] ? {2'b00, w_sel_e, 1'b0} : 13'd0);

   // Final stage helpers.
   logic signed [33:0] term_e, term_c, acc_neg;
   logic [24:0]        lim25;
   logic               sat;
   logic [14:0]        m15;
   logic [15:0]        m16, m16_neg;
   logic               fin_write;
   assign term_e   = e_ff[14] ? -signed'({2'b00, pe_ff}) : signed'({2'b00, pe_ff});
   assign term_c   = ec_ff[14] ? -signed'({2'b00, pc_ff}) : signed'({2'b00, pc_ff});
   assign acc_neg  = -acc_ff;
   assign lim25    = {10'd0, out_limit_ff};
   assign sat      = mag_ff > lim25;
   assign m15      = sat ? out_limit_ff : mag_ff[14:0];
   assign m16      = {1'b0, m15};
   assign m16_neg  = -m16;
   assign fin_write = (state_ff == ST_FIN) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in      = state_ff;
      diff_in       = diff_ff;
      e_in          = e_ff;
      ec_in         = ec_ff;
      last_error_in = last_error_ff;
      qe_mag_in     = qe_mag_ff;
      qc_mag_in     = qc_mag_ff;
      ie_in         = ie_ff;
      ic_in         = ic_ff;
      we0_in        = we0_ff;
      we1_in        = we1_ff;
      wc0_in        = wc0_ff;
      wc1_in        = wc1_ff;
      term_in       = term_ff;
      rneg_in       = rneg_ff;
      s_in          = s_ff;
      abs_s_in      = abs_s_ff;
      gsel_in       = gsel_ff;
      dsel_in       = dsel_ff;
      kp_in         = kp_ff;
      kd_in         = kd_ff;
      pe_in         = pe_ff;
      pc_in         = pc_ff;
      acc_in        = acc_ff;
      mag_in        = mag_ff;
      neg_in        = neg_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      mul_req       = '0;
      div_req       = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               diff_in  = 17'(req_data.setpoint) - 17'(req_data.measured);
               state_in = ST_ERR;
            end
         end
         ST_ERR: begin
            e_in     = e_clamp[14:0];
            state_in = ST_EC;
         end
         ST_EC: begin
            ec_in            = ec_clamp[14:0];
            last_error_in    = 16'(e_ff);
            div_req.start    = 1'b1;
            div_req.divisor  = err_limit_ff;
            div_req.rem_init = e_mag3[15:2];
            div_req.bits     = {e_mag3[1:0], 14'd0};
            div_req.count    = 5'd11;
            state_in         = ST_QE;
         end
         ST_QE: begin
            if (div_done) begin
               qe_mag_in        = (err_limit_ff == 14'd0) ? 11'd0 : div_quo[10:0];
               div_req.start    = 1'b1;
               div_req.divisor  = ec_limit_ff;
               div_req.rem_init = ec_mag3[15:2];
               div_req.bits     = {ec_mag3[1:0], 14'd0};
               div_req.count    = 5'd11;
               state_in         = ST_QC;
            end
         end
         ST_QC: begin
            if (div_done) begin
               qc_mag_in = (ec_limit_ff == 14'd0) ? 11'd0 : div_quo[10:0];
               state_in  = ST_MEMB;
            end
         end
         ST_MEMB: begin
            ie_in    = seg_e;
            ic_in    = seg_c;
            we1_in   = wup_e;
            we0_in   = W_ONE - wup_e;
            wc1_in   = wup_c;
            wc0_in   = W_ONE - wup_c;
            term_in  = 2'd0;
            s_in     = '0;
            state_in = ST_RULE_GO;
         end
         ST_RULE_GO: begin
            mul_req.start  = 1'b1;
            mul_req.mcand  = {8'd0, rule_mcand};
            mul_req.mplier = {w_sel_c, 7'd0};
            mul_req.count  = 5'd10;
            rneg_in        = rule_val[3];
            state_in       = ST_RULE_WAIT;
         end
         ST_RULE_WAIT: begin
            if (mul_done) begin
               s_in = rneg_ff ? (s_ff - signed'(mul_prod[22:0]))
                              : (s_ff + signed'(mul_prod[22:0]));
               term_in  = term_ff + 2'd1;
               state_in = (term_ff == 2'd3) ? ST_ABS : ST_RULE_GO;
            end
         end
         ST_ABS: begin
            abs_s_in = s_ff[22] ? 21'(-s_ff) : s_ff[20:0];
            gsel_in  = 1'b0;
            state_in = ST_GMUL_GO;
         end
         ST_GMUL_GO: begin
            mul_req.start  = 1'b1;
            mul_req.mcand  = abs_s_ff;
            mul_req.mplier = {gsel_ff ? kd_fuzzy_ff : kp_fuzzy_ff, 1'b0};
            mul_req.count  = 5'd16;
            state_in       = ST_GMUL_WAIT;
         end
         ST_GMUL_WAIT: begin
            // Divide the product, shifted down by 18, by six.
            if (mul_done) begin
               div_req.start    = 1'b1;
               div_req.divisor  = SIX;
               div_req.rem_init = {11'd0, mul_prod[36:34]};
               div_req.bits     = mul_prod[33:18];
               div_req.count    = 5'd16;
               state_in         = ST_GDIV_WAIT;
            end
         end
         ST_GDIV_WAIT: begin
            if (div_done) begin
               if (gsel_ff) begin
                  kd_in    = {1'b0, kd_base_ff} + {1'b0, div_quo};
                  dsel_in  = 1'b0;
                  state_in = ST_DMUL_GO;
               end else begin
                  kp_in    = {1'b0, kp_base_ff} + {1'b0, div_quo};
                  gsel_in  = 1'b1;
                  state_in = ST_GMUL_GO;
               end
            end
         end
         ST_DMUL_GO: begin
            mul_req.start  = 1'b1;
            mul_req.mcand  = {4'd0, dsel_ff ? kd_ff : kp_ff};
            mul_req.mplier = {1'b0, dsel_ff ? ec_mag : e_mag, 2'b00};
            mul_req.count  = 5'd15;
            state_in       = ST_DMUL_WAIT;
         end
         ST_DMUL_WAIT: begin
            if (mul_done) begin
               if (dsel_ff) begin
                  pc_in    = mul_prod[31:0];
                  state_in = ST_COMB;
               end else begin
                  pe_in    = mul_prod[31:0];
                  dsel_in  = 1'b1;
                  state_in = ST_DMUL_GO;
               end
            end
         end
         ST_COMB: begin
            acc_in   = term_e + term_c;
            state_in = ST_MAG;
         end
         ST_MAG: begin
            neg_in   = acc_ff[33];
            mag_in   = acc_ff[33] ? acc_neg[32:8] : acc_ff[32:8];
            state_in = ST_FIN;
         end
         ST_FIN: begin
            if (fin_write) begin
               rsp_in.drive     = neg_ff ? signed'(m16_neg) : signed'(m16);
               rsp_in.saturated = sat;
               rsp_valid_in     = 1'b1;
               state_in         = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      diff_ff  <= diff_in;
      e_ff     <= e_in;
      ec_ff    <= ec_in;
      qe_mag_ff <= qe_mag_in;
      qc_mag_ff <= qc_mag_in;
      ie_ff    <= ie_in;
      ic_ff    <= ic_in;
      we0_ff   <= we0_in;
      we1_ff   <= we1_in;
      wc0_ff   <= wc0_in;
      wc1_ff   <= wc1_in;
      term_ff  <= term_in;
      rneg_ff  <= rneg_in;
      s_ff     <= s_in;
      abs_s_ff <= abs_s_in;
      gsel_ff  <= gsel_in;
      dsel_ff  <= dsel_in;
      kp_ff    <= kp_in;
      kd_ff    <= kd_in;
      pe_ff    <= pe_in;
      pc_ff    <= pc_in;
      acc_ff   <= acc_in;
      mag_ff   <= mag_in;
      neg_ff   <= neg_in;
      rsp_ff   <= rsp_in;
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         last_error_ff <= '0;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         last_error_ff <= last_error_in;
      end
   end

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         err_limit_ff <= ERR_LIMIT_RST;
         ec_limit_ff  <= EC_LIMIT_RST;
         out_limit_ff <= OUT_LIMIT_RST;
         kp_base_ff   <= KP_BASE_RST;
         kd_base_ff   <= KD_BASE_RST;
         kp_fuzzy_ff  <= KP_FUZZY_RST;
         kd_fuzzy_ff  <= KD_FUZZY_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_ERR_LIMIT: err_limit_ff <= csr_data[13:0];
            CSR_EC_LIMIT:  ec_limit_ff  <= csr_data[13:0];
            CSR_OUT_LIMIT: out_limit_ff <= csr_data[14:0];
            CSR_KP_BASE:   kp_base_ff   <= csr_data;
            CSR_KD_BASE:   kd_base_ff   <= csr_data;
            CSR_KP_FUZZY:  kp_fuzzy_ff  <= csr_data;
            CSR_KD_FUZZY:  kd_fuzzy_ff  <= csr_data;
            default: begin
            end
         endcase
      end
   end

   // The quantized magnitudes never exceed full scale.
   a_qmag: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_MEMB |-> (qe_mag_ff <= Q_FULL[10:0]) && (qc_mag_ff <= Q_FULL[10:0]))
      else $error("quantized value beyond full scale");

   // The two membership weights of each input always add up to one.
   a_wsum: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_RULE_GO |->
         ({1'b0, we0_ff} + {1'b0, we1_ff} == {1'b0, W_ONE}) &&
         ({1'b0, wc0_ff} + {1'b0, wc1_ff} == {1'b0, W_ONE}))
      else $error("membership weights do not sum to one");

   // The rule strength stays within six levels.
   a_sbound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_GMUL_GO |-> abs_s_ff <= S_MAX)
      else $error("rule sum out of range");

   // A multiplier result only arrives while a product is awaited.
   a_muldone: assert property (@(posedge clock) disable iff (reset)
      mul_done |-> (state_ff == ST_RULE_WAIT) || (state_ff == ST_GMUL_WAIT) ||
                   (state_ff == ST_DMUL_WAIT))
      else $error("unexpected multiplier completion");

   // Reset leaves the controller idle with no response pending.
   a_reset: assert property (@(posedge clock)
      reset |=> (state_ff == ST_IDLE) && !rsp_valid_ff)
      else $error("controller not idle after reset");

endmodule
